[rtl/core/sts_pkg.sv]
// Shared types and constants for the score table search block.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int KeyW       = 20;
  localparam int GradeW     = 8;
  localparam int GradeMax   = 100;
  localparam int HitW       = 10;
  localparam int CmpW       = 11;

  typedef enum logic [1:0] {
    ReqLoad   = 2'd0,
    ReqLinear = 2'd1,
    ReqBinary = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusRange = 2'd2
  } status_e;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [KeyW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic            found;
    logic [HitW-1:0] hit_index;
    logic [CmpW-1:0] compare_count;
    status_e         status;
  } res_t;

endpackage

[rtl/core/sts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sts_ram #(
  parameter int Width = 20,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sts_ctrl.sv]
// Request sequencer: loads, linear scan and binary search over the key table.
`timescale 1ns / 1ps

module sts_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [sts_pkg::GradeW-1:0] grade_a_i,
  input  logic [sts_pkg::GradeW-1:0] grade_b_i,
  input  logic [sts_pkg::GradeW-1:0] grade_c_i,
  input  logic [sts_pkg::KeyW-1:0]   target_key_i,
  output sts_pkg::ram_req_t          ram_req_o,
  input  logic [sts_pkg::KeyW-1:0]   ram_rdata_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output sts_pkg::res_t             res_o
);

  import sts_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StLdMul,
    StLdWr,
    StLin,
    StBinIssue,
    StBinCmp,
    StResp
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic [GradeW-1:0]   a_q, b_q, c_q;
  logic [KeyW-1:0]     key_q;
  logic [15:0]         ab_q;
  logic [IdxW-1:0]     idx_q;
  logic [IdxW-1:0]     mid_q;
  logic [CntW-1:0]     lo_q;
  logic [CntW-1:0]     hi1_q;
  logic [CmpW-1:0]     cmp_q;
  res_t                res_q;

  logic [23:0]         abc;
  logic [CntW-1:0]     span;
  logic [CntW-1:0]     bin_mid;
  logic [CntW-1:0]     idx_next;
  logic                grade_bad;

  assign abc       = 24'(ab_q) * 24'(c_q);
  assign span      = hi1_q - CntW'(1) - lo_q;
  assign bin_mid   = lo_q + (span >> 1);
  assign idx_next  = CntW'(idx_q) + CntW'(1);
  assign grade_bad = (grade_a_i > GradeW'(GradeMax)) || (grade_b_i > GradeW'(GradeMax)) ||
                     (grade_c_i > GradeW'(GradeMax));

  always_comb begin
    ram_req_o.we    = (state_q == StLdWr);
    ram_req_o.waddr = count_q[IdxW-1:0];
    ram_req_o.wdata = abc[KeyW-1:0];
    case (state_q)
      StLin:      ram_req_o.raddr = idx_next[IdxW-1:0];
      StBinIssue: ram_req_o.raddr = bin_mid[IdxW-1:0];
      default:    ram_req_o.raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            a_q   <= grade_a_i;
            b_q   <= grade_b_i;
            c_q   <= grade_c_i;
            key_q <= target_key_i;
            idx_q <= '0;
            lo_q  <= '0;
            hi1_q <= count_q;
            cmp_q <= '0;
            res_q <= '{found: 1'b0, hit_index: '0, compare_count: '0, status: StatusOk};
            state_q <= StResp;
            case (req_e'(req_type_i))
              ReqLoad: begin
                if (count_q >= CntW'(TableDepth)) begin
                  res_q.status <= StatusFull;
                end else if (grade_bad) begin
                  res_q.status <= StatusRange;
                end else begin
                  state_q <= StLdMul;
                end
              end
              ReqLinear: begin
                if (count_q != '0) begin
                  state_q <= StLin;
                end
              end
              ReqBinary: begin
                state_q <= StBinIssue;
              end
              default: begin
                state_q <= StResp;
              end
            endcase
          end
        end
        StLdMul: begin
          ab_q    <= 16'(a_q) * 16'(b_q);
          state_q <= StLdWr;
        end
        StLdWr: begin
          res_q.hit_index <= HitW'(count_q[IdxW-1:0]);
          count_q         <= count_q + CntW'(1);
          state_q         <= StResp;
        end
        StLin: begin
          if (ram_rdata_i == key_q) begin
            res_q.found         <= 1'b1;
            res_q.hit_index     <= HitW'(idx_q);
            res_q.compare_count <= CmpW'(idx_next);
            state_q             <= StResp;
          end else if (idx_next == count_q) begin
            res_q.compare_count <= CmpW'(idx_next);
            state_q             <= StResp;
          end else begin
            idx_q <= idx_next[IdxW-1:0];
          end
        end
        StBinIssue: begin
          if (lo_q < hi1_q) begin
            mid_q   <= bin_mid[IdxW-1:0];
            state_q <= StBinCmp;
          end else begin
            res_q.compare_count <= cmp_q;
            state_q             <= StResp;
          end
        end
        StBinCmp: begin
          cmp_q <= cmp_q + CmpW'(1);
          if (ram_rdata_i == key_q) begin
            res_q.found         <= 1'b1;
            res_q.hit_index     <= HitW'(mid_q);
            res_q.compare_count <= cmp_q + CmpW'(1);
            state_q             <= StResp;
          end else begin
            if (ram_rdata_i < key_q) begin
              lo_q <= CntW'(mid_q) + CntW'(1);
            end else begin
              hi1_q <= CntW'(mid_q);
            end
            state_q <= StBinIssue;
          end
        end
        StResp: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign res_valid_o = (state_q == StResp);
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("Entry count exceeds the table depth.");

  a_count_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == StLdWr))
    else $error("Entry count changed outside a table write.");

  a_lin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLin) |-> (CntW'(idx_q) < count_q))
    else $error("Linear scan index passed the last stored entry.");

  a_bin_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBinCmp) |-> ((CntW'(mid_q) >= lo_q) && (CntW'(mid_q) < hi1_q)))
    else $error("Binary search midpoint is outside the live window.");

endmodule

[rtl/core/score_table_search.sv]
// Top level of the score table search block with its key memory and output register.
// A load multiplies the first two grades, then writes the product with the third grade
// to the next free entry before it gives its result; a refused load or an empty linear
// search gives its result without touching the memory. A linear scan compares stored
// entries in order until a hit or the last entry. A binary search issues a midpoint read
// and then compares the registered read data for each step. One item is in work at a time.
// Reset clears the entry count and the control state; the key memory is not cleared.
`timescale 1ns / 1ps

module score_table_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [sts_pkg::GradeW-1:0] grade_a_i,
  input  logic [sts_pkg::GradeW-1:0] grade_b_i,
  input  logic [sts_pkg::GradeW-1:0] grade_c_i,
  input  logic [sts_pkg::KeyW-1:0]   target_key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [sts_pkg::HitW-1:0]   hit_index_o,
  output logic [sts_pkg::CmpW-1:0]   compare_count_o,
  output logic [1:0]                 status_o
);

  import sts_pkg::*;

  ram_req_t        ram_req;
  logic [KeyW-1:0] ram_rdata;
  logic            res_valid;
  logic            res_ready;
  res_t            res;
  res_t            out_q;
  logic            out_valid_q;

  sts_ram #(
    .Width (KeyW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  sts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .grade_a_i    (grade_a_i),
    .grade_b_i    (grade_b_i),
    .grade_c_i    (grade_c_i),
    .target_key_i (target_key_i),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_q.found;
  assign hit_index_o     = out_q.hit_index;
  assign compare_count_o = out_q.compare_count;
  assign status_o        = out_q.status;

endmodule
